// ----- sv/lti_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lti_pkg
// Widths, types and helpers shared by the line / triangle intersection core.
// ----------------------------------------------------------------------------
package lti_pkg;

    localparam int COORD_WIDTH    = 16;
    localparam int BARY_FRAC_BITS = 15;
    localparam int PT_W           = 48;
    localparam int BARY_W         = 16;

    localparam int DIFF_W = COORD_WIDTH + 1;       // point differences
    localparam int PROD_W = 2 * DIFF_W;            // cross product terms
    localparam int CRS_W  = PROD_W + 1;            // cross product components
    localparam int DOT_W  = DIFF_W + CRS_W;        // dot product terms
    localparam int VOL_W  = DOT_W + 2;             // signed volumes
    localparam int MAG_W  = VOL_W;                 // volume magnitudes
    localparam int SUM_W  = MAG_W + 2;             // volume sum
    localparam int REM_W  = SUM_W + 1;             // divider remainder

    localparam int STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES = (BARY_FRAC_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    localparam int IN_TDATA_W  = 5 * PT_W;
    localparam int OUT_TDATA_W = 3 * BARY_W;
    localparam int OUT_TUSER_W = 2;

    localparam int HIT_BIT = 0;
    localparam int DEG_BIT = 1;

    typedef logic signed [DIFF_W-1:0] t_diff;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [CRS_W-1:0]  t_crs;
    typedef logic signed [DOT_W-1:0]  t_dot;
    typedef logic signed [VOL_W-1:0]  t_vol;
    typedef logic        [MAG_W-1:0]  t_mag;
    typedef logic        [SUM_W-1:0]  t_sum;
    typedef logic        [REM_W-1:0]  t_rem;
    typedef logic [BARY_FRAC_BITS-1:0] t_quo;

    // signed coordinate k of a packed point, extended by one bit
    function automatic t_diff coord(input logic [PT_W-1:0] pt, input int k);
        logic signed [COORD_WIDTH-1:0] c;
        c = pt[k*COORD_WIDTH +: COORD_WIDTH];
        return t_diff'(c);
    endfunction

    function automatic t_mag vol_abs(input t_vol x);
        return x[VOL_W-1] ? t_mag'(-x) : t_mag'(x);
    endfunction

endpackage
`default_nettype wire

// ----- sv/line_triangle_intersection_core.sv -----
`default_nettype none
// Pipeline: 7 + DIV_STAGES register stages (12 at 15 fraction bits).
// Throughput: one word per cycle if not stalled; the three restoring dividers
//   are unrolled three quotient bits per stage; no unit is reused across items.
// The whole pipeline advances together; it holds while the output word waits.
// Reset (i_rst_n low, synchronous) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// line_triangle_intersection_core
// Scalar triple product line / triangle test with barycentric weights.
// ----------------------------------------------------------------------------
module line_triangle_intersection_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    output      logic                              s_axis_tready,
    // line_start, line_end, vertex_a, vertex_b, vertex_c (48 bits each)
    input  wire logic [lti_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output      logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // bary_u, bary_v, bary_w (16 bits each)
    output      logic [lti_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // hit, degenerate
    output      logic [lti_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);
    import lti_pkg::*;

    localparam int NST = 7 + DIV_STAGES;

    logic           ce;
    logic [NST-1:0] r_vld;

    assign ce            = ~r_vld[NST-1] | m_axis_tready;
    assign s_axis_tready = ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (ce) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // stage 1: offsets from p
    t_diff r_pq [3], r_pa [3], r_pb [3], r_pc [3];
    // stage 2: cross product terms
    t_prod r_mp [6], r_np [6];
    t_diff r2_pq [3], r2_pa [3], r2_pb [3];
    // stage 3: cross products m = pq x pc, n = pb x pa
    t_crs  r_m [3], r_n [3];
    t_diff r3_pq [3], r3_pa [3], r3_pb [3];
    // stage 4: dot product terms
    t_dot  r_du [3], r_dv [3], r_dw [3];
    // stage 5: volumes
    t_vol  r_u, r_v, r_w;
    // stage 6: sign test and magnitudes
    t_mag  r_mu, r_mv, r_mw;
    logic  r6_hit, r6_deg;
    // stage 7: sum and exact-one flags
    t_rem  r_rem [DIV_STAGES+1][3];
    t_quo  r_quo [DIV_STAGES+1][3];
    logic  r_eq  [DIV_STAGES+1][3];
    t_sum  r_s   [DIV_STAGES+1];
    logic  r_hit [DIV_STAGES+1];
    logic  r_deg [DIV_STAGES+1];

    function automatic t_diff pt_c(input int idx, input int k);
        return coord(s_axis_tdata[idx*PT_W +: PT_W], k);
    endfunction

    t_vol  n_u, n_v, n_w;
    logic  n_neg, n_pos;
    t_sum  n_s;

    always_comb begin
        n_u = t_vol'(r_du[0]) + t_vol'(r_du[1]) + t_vol'(r_du[2]);
        n_v = -(t_vol'(r_dv[0]) + t_vol'(r_dv[1]) + t_vol'(r_dv[2]));
        n_w = t_vol'(r_dw[0]) + t_vol'(r_dw[1]) + t_vol'(r_dw[2]);
        n_neg = r_u[VOL_W-1] | r_v[VOL_W-1] | r_w[VOL_W-1];
        n_pos = (~r_u[VOL_W-1] & (r_u != '0)) | (~r_v[VOL_W-1] & (r_v != '0))
              | (~r_w[VOL_W-1] & (r_w != '0));
        n_s = t_sum'(r_mu) + t_sum'(r_mv) + t_sum'(r_mw);
    end

    // divider stages: restoring division, STEPS_PER_STAGE bits each
    t_rem n_rem [DIV_STAGES][3];
    t_quo n_quo [DIV_STAGES][3];

    always_comb begin
        for (int st = 0; st < DIV_STAGES; st++) begin
            for (int l = 0; l < 3; l++) begin
                n_rem[st][l] = r_rem[st][l];
                n_quo[st][l] = r_quo[st][l];
                for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                    if (st * STEPS_PER_STAGE + j < BARY_FRAC_BITS) begin
                        n_rem[st][l] = n_rem[st][l] << 1;
                        n_quo[st][l] = n_quo[st][l] << 1;
                        if (n_rem[st][l] >= t_rem'(r_s[st])) begin
                            n_rem[st][l] = n_rem[st][l] - t_rem'(r_s[st]);
                            n_quo[st][l][0] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int k = 0; k < 3; k++) begin
                r_pq[k] <= pt_c(1, k) - pt_c(0, k);
                r_pa[k] <= pt_c(2, k) - pt_c(0, k);
                r_pb[k] <= pt_c(3, k) - pt_c(0, k);
                r_pc[k] <= pt_c(4, k) - pt_c(0, k);
                r2_pq[k] <= r_pq[k];
                r2_pa[k] <= r_pa[k];
                r2_pb[k] <= r_pb[k];
                r3_pq[k] <= r2_pq[k];
                r3_pa[k] <= r2_pa[k];
                r3_pb[k] <= r2_pb[k];
            end
            for (int k = 0; k < 3; k++) begin
                r_mp[2*k]   <= t_prod'(r_pq[(k+1)%3] * r_pc[(k+2)%3]);
                r_mp[2*k+1] <= t_prod'(r_pq[(k+2)%3] * r_pc[(k+1)%3]);
                r_np[2*k]   <= t_prod'(r_pb[(k+1)%3] * r_pa[(k+2)%3]);
                r_np[2*k+1] <= t_prod'(r_pb[(k+2)%3] * r_pa[(k+1)%3]);
                r_m[k] <= t_crs'(r_mp[2*k]) - t_crs'(r_mp[2*k+1]);
                r_n[k] <= t_crs'(r_np[2*k]) - t_crs'(r_np[2*k+1]);
                r_du[k] <= t_dot'(r3_pb[k] * r_m[k]);
                r_dv[k] <= t_dot'(r3_pa[k] * r_m[k]);
                r_dw[k] <= t_dot'(r3_pq[k] * r_n[k]);
            end
            r_u <= n_u;
            r_v <= n_v;
            r_w <= n_w;
            r_mu   <= vol_abs(r_u);
            r_mv   <= vol_abs(r_v);
            r_mw   <= vol_abs(r_w);
            r6_hit <= ~(n_neg & n_pos) & (n_neg | n_pos);
            r6_deg <= ~n_neg & ~n_pos;
            // zero the weights on a miss so they leave as zero
            r_rem[0][0] <= r6_hit ? t_rem'(r_mu) : '0;
            r_rem[0][1] <= r6_hit ? t_rem'(r_mv) : '0;
            r_rem[0][2] <= r6_hit ? t_rem'(r_mw) : '0;
            r_eq[0][0]  <= r6_hit & (t_sum'(r_mu) == n_s);
            r_eq[0][1]  <= r6_hit & (t_sum'(r_mv) == n_s);
            r_eq[0][2]  <= r6_hit & (t_sum'(r_mw) == n_s);
            for (int l = 0; l < 3; l++) r_quo[0][l] <= '0;
            r_s[0]   <= r6_hit ? n_s : t_sum'(1);
            r_hit[0] <= r6_hit;
            r_deg[0] <= r6_deg;
            for (int st = 0; st < DIV_STAGES; st++) begin
                for (int l = 0; l < 3; l++) begin
                    r_rem[st+1][l] <= n_rem[st][l];
                    r_quo[st+1][l] <= n_quo[st][l];
                    r_eq[st+1][l]  <= r_eq[st][l];
                end
                r_s[st+1]   <= r_s[st];
                r_hit[st+1] <= r_hit[st];
                r_deg[st+1] <= r_deg[st];
            end
        end
    end

    // weight of exactly one is 2^frac; wider results saturate
    function automatic logic [BARY_W-1:0] weight(input logic eq, input t_quo q);
        logic [BARY_FRAC_BITS:0] full;
        full = eq ? {1'b1, {BARY_FRAC_BITS{1'b0}}} : {1'b0, q};
        if (BARY_FRAC_BITS + 1 > BARY_W && (full >> BARY_W) != '0)
            return '1;
        return BARY_W'(full);
    endfunction

    assign m_axis_tvalid = r_vld[NST-1];
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            m_axis_tdata[l*BARY_W +: BARY_W] =
                weight(r_eq[DIV_STAGES][l], r_quo[DIV_STAGES][l]);
        end
        m_axis_tuser[HIT_BIT] = r_hit[DIV_STAGES];
        m_axis_tuser[DEG_BIT] = r_deg[DIV_STAGES];
    end

    a_hit_deg_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[HIT_BIT] && m_axis_tuser[DEG_BIT]))
        else $error("hit and degenerate both set");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[HIT_BIT]) |-> (m_axis_tdata == '0))
        else $error("nonzero weights without hit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output word changed while stalled");
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output back-pressure");

endmodule
`default_nettype wire
